@@ rtl/lrupr_pkg.sv @@
// Shared types and field widths for the LRU page cache.
`timescale 1ns / 1ps

package lrupr_pkg;

  // Fixed port field widths
  localparam int PAGE_W = 16;
  localparam int SLOT_W = 4;

  // Lookup result handed from the engine to the output stage
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evict_valid;
    logic [PAGE_W-1:0] evict_page;
  } lrupr_res_t;

endpackage

@@ rtl/lrupr_mem.sv @@
// Simple dual-port slot memory: one write and one registered read per cycle.
`timescale 1ns / 1ps

module lrupr_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 20
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/lrupr_engine.sv @@
// Lookup sequencer: scan pass for hit / empty / victim, then a rank update pass.
`timescale 1ns / 1ps

module lrupr_engine #(
  parameter int MAX_ENTRIES = 16,
  parameter int PAGE_BITS   = 16,
  parameter int NW          = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [NW-1:0]             n_act,
  input  logic                      start,
  input  logic [lrupr_pkg::PAGE_W-1:0] req_page,
  output logic                      busy,
  output logic                      res_valid,
  output lrupr_pkg::lrupr_res_t     res,
  input  logic                      res_ack
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RW = IW;
  localparam int DW = PAGE_BITS + RW;
  localparam logic [RW-1:0] RANK_MAX = RW'(MAX_ENTRIES - 1);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    DECIDE,
    UPDATE,
    DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [NW-1:0]        rd_idx_r, rd_idx_nxt;
  logic                 pipe_vld_r, pipe_vld_nxt;
  logic [IW-1:0]        pipe_idx_r, pipe_idx_nxt;
  logic [PAGE_BITS-1:0] req_r, req_nxt;
  logic                 hit_fnd_r, hit_fnd_nxt;
  logic [IW-1:0]        hit_idx_r, hit_idx_nxt;
  logic [RW-1:0]        hit_rank_r, hit_rank_nxt;
  logic                 emp_fnd_r, emp_fnd_nxt;
  logic [IW-1:0]        emp_idx_r, emp_idx_nxt;
  logic [RW-1:0]        best_rank_r, best_rank_nxt;
  logic [IW-1:0]        best_idx_r, best_idx_nxt;
  logic [PAGE_BITS-1:0] best_page_r, best_page_nxt;
  logic [IW-1:0]        sel_idx_r, sel_idx_nxt;
  logic                 was_valid_r, was_valid_nxt;
  logic [RW-1:0]        old_rank_r, old_rank_nxt;
  logic                 evict_r, evict_nxt;
  logic [PAGE_BITS-1:0] evict_page_r, evict_page_nxt;
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;

  logic                 rd_en;
  logic [DW-1:0]        rd_data;
  logic [PAGE_BITS-1:0] rd_page;
  logic [RW-1:0]        rd_rank;
  logic                 rd_slot_vld;
  logic                 wr_en;
  logic [DW-1:0]        wr_data;

  // Slot storage: page number over recency rank
  lrupr_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r[IW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (pipe_idx_r),
    .wr_data (wr_data)
  );

  assign rd_page     = rd_data[DW-1:RW];
  assign rd_rank     = rd_data[RW-1:0];
  assign rd_slot_vld = valid_r[pipe_idx_r];

  // One read per cycle while walking the active slots
  assign rd_en = ((state_r == SCAN) || (state_r == UPDATE)) && (rd_idx_r < n_act);

  // Rank update write-back, one slot per cycle behind the read
  always_comb begin
    wr_en   = 1'b0;
    wr_data = {rd_page, rd_rank};
    if ((state_r == UPDATE) && pipe_vld_r) begin
      if (pipe_idx_r == sel_idx_r) begin
        wr_en   = 1'b1;
        wr_data = {req_r, RW'(0)};
      end else if (rd_slot_vld && (!was_valid_r || (rd_rank < old_rank_r)) &&
                   (rd_rank != RANK_MAX)) begin
        wr_en   = 1'b1;
        wr_data = {rd_page, rd_rank + RW'(1)};
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    pipe_vld_nxt   = rd_en;
    pipe_idx_nxt   = rd_idx_r[IW-1:0];
    req_nxt        = req_r;
    hit_fnd_nxt    = hit_fnd_r;
    hit_idx_nxt    = hit_idx_r;
    hit_rank_nxt   = hit_rank_r;
    emp_fnd_nxt    = emp_fnd_r;
    emp_idx_nxt    = emp_idx_r;
    best_rank_nxt  = best_rank_r;
    best_idx_nxt   = best_idx_r;
    best_page_nxt  = best_page_r;
    sel_idx_nxt    = sel_idx_r;
    was_valid_nxt  = was_valid_r;
    old_rank_nxt   = old_rank_r;
    evict_nxt      = evict_r;
    evict_page_nxt = evict_page_r;
    valid_nxt      = valid_r;

    if (rd_en) begin
      rd_idx_nxt = rd_idx_r + NW'(1);
    end

    unique case (state_r)
      IDLE: begin
        if (start) begin
          req_nxt     = PAGE_BITS'(req_page);
          rd_idx_nxt  = '0;
          hit_fnd_nxt = 1'b0;
          emp_fnd_nxt = 1'b0;
          state_nxt   = SCAN;
        end
      end

      SCAN: begin
        if (pipe_vld_r) begin
          // first valid match wins
          if (rd_slot_vld && (rd_page == req_r) && !hit_fnd_r) begin
            hit_fnd_nxt  = 1'b1;
            hit_idx_nxt  = pipe_idx_r;
            hit_rank_nxt = rd_rank;
          end
          // lowest empty slot
          if (!rd_slot_vld && !emp_fnd_r) begin
            emp_fnd_nxt = 1'b1;
            emp_idx_nxt = pipe_idx_r;
          end
          // oldest rank, lowest index among equals
          if ((pipe_idx_r == '0) || (rd_rank > best_rank_r)) begin
            best_rank_nxt = rd_rank;
            best_idx_nxt  = pipe_idx_r;
            best_page_nxt = rd_page;
          end
        end
        if ((rd_idx_r == n_act) && !pipe_vld_r) begin
          state_nxt = DECIDE;
        end
      end

      DECIDE: begin
        rd_idx_nxt = '0;
        if (hit_fnd_r) begin
          sel_idx_nxt    = hit_idx_r;
          was_valid_nxt  = 1'b1;
          old_rank_nxt   = hit_rank_r;
          evict_nxt      = 1'b0;
          evict_page_nxt = '0;
        end else if (emp_fnd_r) begin
          sel_idx_nxt    = emp_idx_r;
          was_valid_nxt  = 1'b0;
          old_rank_nxt   = '0;
          evict_nxt      = 1'b0;
          evict_page_nxt = '0;
        end else begin
          sel_idx_nxt    = best_idx_r;
          was_valid_nxt  = 1'b1;
          old_rank_nxt   = best_rank_r;
          evict_nxt      = 1'b1;
          evict_page_nxt = best_page_r;
        end
        state_nxt = UPDATE;
      end

      UPDATE: begin
        if ((rd_idx_r == n_act) && !pipe_vld_r) begin
          valid_nxt[sel_idx_r] = 1'b1;
          state_nxt            = DONE;
        end
      end

      DONE: begin
        if (res_ack) begin
          state_nxt = IDLE;
        end
      end

      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= IDLE;
      rd_idx_r   <= '0;
      pipe_vld_r <= 1'b0;
      hit_fnd_r  <= 1'b0;
      emp_fnd_r  <= 1'b0;
      evict_r    <= 1'b0;
      valid_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      rd_idx_r   <= rd_idx_nxt;
      pipe_vld_r <= pipe_vld_nxt;
      hit_fnd_r  <= hit_fnd_nxt;
      emp_fnd_r  <= emp_fnd_nxt;
      evict_r    <= evict_nxt;
      valid_r    <= valid_nxt;
    end
    pipe_idx_r   <= pipe_idx_nxt;
    req_r        <= req_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_rank_r   <= hit_rank_nxt;
    emp_idx_r    <= emp_idx_nxt;
    best_rank_r  <= best_rank_nxt;
    best_idx_r   <= best_idx_nxt;
    best_page_r  <= best_page_nxt;
    sel_idx_r    <= sel_idx_nxt;
    was_valid_r  <= was_valid_nxt;
    old_rank_r   <= old_rank_nxt;
    evict_page_r <= evict_page_nxt;
  end

  // Result toward the output stage
  assign busy            = (state_r != IDLE);
  assign res_valid       = (state_r == DONE);
  assign res.hit         = hit_fnd_r;
  assign res.slot        = lrupr_pkg::SLOT_W'(sel_idx_r);
  assign res.evict_valid = evict_r;
  assign res.evict_page  = lrupr_pkg::PAGE_W'(evict_page_r);

  // Checks
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SCAN) |-> !wr_en)
    else $error("slot memory written during scan");

  a_pipe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_vld_r |-> (NW'(pipe_idx_r) < n_act))
    else $error("slot index beyond active entries");

  a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(valid_r) >= $past($countones(valid_r))))
    else $error("valid bit dropped");

  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.evict_valid) |-> !res.hit)
    else $error("eviction reported on a hit");

  a_slot_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ack) |=> valid_r[sel_idx_r])
    else $error("chosen slot not marked valid");

endmodule

@@ rtl/lru_page_replacement.sv @@
// Top level of the LRU page cache: config register, counters and output stage.
//
// Usage: a request carries one page number on in_page_number with in_valid;
// it is taken at a clock edge where in_valid is high and in_stall is low.
// Each request yields exactly one result on the out_ channel (hit, slot,
// evicted page, saturating miss and request counts), taken where out_valid
// is high and out_stall is low. One request is in flight at a time:
// in_stall stays high from acceptance until the result is loaded into the
// output register. The scan pass reads the slots in use one per cycle from
// the slot memory for hit, empty slot and oldest rank; a decide step
// follows; the update pass rewrites the ranks one slot per cycle through
// the memory's write port; a done state hands the result over. The next
// request is taken only once the engine is back in idle. The output
// register lets the next request start while a result waits; if out_stall
// holds, the engine waits after its update pass. cfg_wr_en/cfg_wr_data set
// the number of slots in use (0 acts as 1, values above the depth act as
// the depth); write it only while idle. Synchronous reset clears all valid
// bits and both counters and sets the slot count to 16; ranks of empty
// slots are never used.
`timescale 1ns / 1ps

module lru_page_replacement #(
  parameter int MAX_ENTRIES = 16,
  parameter int PAGE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_page_number,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [3:0]  out_slot,
  output logic        out_evicted_valid,
  output logic [15:0] out_evicted_page,
  output logic [31:0] out_miss_count,
  output logic [31:0] out_request_count
);

  localparam int NW     = $clog2(MAX_ENTRIES + 1);
  localparam int CFG_W  = 5;
  localparam int CNT_W  = 32;
  localparam logic [CFG_W-1:0] ENTRIES_RST = CFG_W'(16);

  logic [CFG_W-1:0]  cfg_r;
  logic [NW-1:0]     n_act;
  logic              busy;
  logic              start;
  logic              res_valid;
  logic              res_ack;
  lrupr_pkg::lrupr_res_t res;

  logic              out_valid_r, out_valid_nxt;
  lrupr_pkg::lrupr_res_t out_res_r, out_res_nxt;
  logic [CNT_W-1:0]  miss_cnt_r, miss_cnt_nxt;
  logic [CNT_W-1:0]  req_cnt_r, req_cnt_nxt;

  // Slot count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ENTRIES_RST;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // Clamp slot count into 1..MAX_ENTRIES
  always_comb begin
    if (cfg_r == '0) begin
      n_act = NW'(1);
    end else if (int'(cfg_r) > MAX_ENTRIES) begin
      n_act = NW'(MAX_ENTRIES);
    end else begin
      n_act = NW'(cfg_r);
    end
  end

  assign start    = in_valid && !busy;
  assign in_stall = busy;
  assign res_ack  = !out_valid_r || !out_stall;

  lrupr_engine #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .PAGE_BITS   (PAGE_BITS),
    .NW          (NW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_act     (n_act),
    .start     (start),
    .req_page  (in_page_number),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .res_ack   (res_ack)
  );

  // Output register and saturating counters
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    miss_cnt_nxt  = miss_cnt_r;
    req_cnt_nxt   = req_cnt_r;
    if (res_valid && res_ack) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
      if (!res.hit && (miss_cnt_r != '1)) begin
        miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
      end
      if (req_cnt_r != '1) begin
        req_cnt_nxt = req_cnt_r + CNT_W'(1);
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      miss_cnt_r  <= '0;
      req_cnt_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      req_cnt_r   <= req_cnt_nxt;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_res_r.hit;
  assign out_slot          = out_res_r.slot;
  assign out_evicted_valid = out_res_r.evict_valid;
  assign out_evicted_page  = out_res_r.evict_page;
  assign out_miss_count    = miss_cnt_r;
  assign out_request_count = req_cnt_r;

endmodule
